FILE: design/sm4_pkg.sv
// sm4 package: payload and pipeline types, cipher constants and round functions
package sm4_pkg;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
   } key_type;

   // one pipeline stage: data words, key schedule words, round key for the next stage
   typedef struct packed {
      logic [3:0][31:0] x;
      logic [3:0][31:0] k;
      logic [31:0]      rk;
   } stage_type;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   localparam logic [7:0] CK_STEP = 8'd7;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [31:0] sub_word(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // data round linear transform
   function automatic logic [31:0] round_mix(input logic [31:0] v);
      logic [31:0] b;
      b = sub_word(v);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // key schedule linear transform
   function automatic logic [31:0] sched_mix(input logic [31:0] v);
      logic [31:0] b;
      b = sub_word(v);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // byte j of word i is (4*i + j) * 7 modulo 256
   function automatic logic [31:0] ck_word(input logic [4:0] idx);
      logic [31:0] w;
      logic [7:0]  n;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         n = {1'b0, idx, 2'b00} + 8'(j);
         w = {w[23:0], 8'(n * CK_STEP)};
      end
      return w;
   endfunction

endpackage

FILE: design/sm4_csr.sv
// sm4 key registers behind the apb-style configuration port
module sm4_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [63:0]     pwdata,
   output logic [63:0]     prdata,
   output logic            pready,
   output sm4_pkg::key_type key
);

   localparam logic SEL_KEY_HIGH = 1'b0;
   localparam logic SEL_KEY_LOW  = 1'b1;

   sm4_pkg::key_type key_ff;
   sm4_pkg::key_type key_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         case (paddr[3])
            SEL_KEY_HIGH: key_in.key_high = pwdata;
            SEL_KEY_LOW:  key_in.key_low  = pwdata;
            default:      key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign prdata = (paddr[3] == SEL_KEY_LOW) ? key_ff.key_low : key_ff.key_high;
   assign key    = key_ff;

endmodule

FILE: design/sm4_round.sv
// sm4 pipeline stage: one data round and the next key schedule step
module sm4_round #(
   parameter int STAGE = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  sm4_pkg::stage_type stage_i,
   output logic               valid_o,
   output sm4_pkg::stage_type stage_o
);

   sm4_pkg::stage_type stage_ff;
   sm4_pkg::stage_type stage_in;
   logic               valid_ff;
   logic [31:0]        t_data;
   logic [31:0]        t_key;

   always_comb begin
      t_data = stage_i.x[0]
             ^ sm4_pkg::round_mix(stage_i.x[1] ^ stage_i.x[2] ^ stage_i.x[3] ^ stage_i.rk);
      t_key  = stage_i.k[0]
             ^ sm4_pkg::sched_mix(stage_i.k[1] ^ stage_i.k[2] ^ stage_i.k[3]
                                  ^ sm4_pkg::ck_word(5'(STAGE)));
      stage_in.x  = {t_data, stage_i.x[3], stage_i.x[2], stage_i.x[1]};
      stage_in.k  = {t_key, stage_i.k[3], stage_i.k[2], stage_i.k[1]};
      stage_in.rk = t_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;

endmodule

FILE: design/sm4_block_encrypt.sv
// sm4 block encrypt top level: key registers, key setup stage and the round pipeline
//
// usage: write the key over the apb-style port (key_high at 0x0, key_low at 0x8),
// then present plaintext blocks on req_payload with start. busy is always low, so
// a block is taken at every rising edge where start is high, one per cycle.
// each block carries its own copy of the key down the pipeline, so a key change
// applies to every block accepted after the write.
// the ciphertext appears on rsp_payload with rsp_valid high for one cycle, after the
// block passes through one key setup stage, then one stage per round, each holding one
// s-box layer for data and one for the key.
// throughput: one block per cycle, set by the fully unrolled round stages.
// reset: synchronous, clears the key registers to zero and every stage valid
// bit, so blocks in flight are dropped and no result follows.
// the receiver has no way to stall; a result not taken in its cycle is gone.
module sm4_block_encrypt #(
   parameter int ROUNDS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sm4_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   output sm4_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [63:0]              pwdata,
   output logic [63:0]              prdata,
   output logic                     pready
);

   sm4_pkg::key_type   key;
   sm4_pkg::stage_type stage [ROUNDS+1];
   logic               stage_v [ROUNDS+1];
   sm4_pkg::stage_type setup_in;
   sm4_pkg::stage_type setup_ff;
   logic               setup_v_ff;
   logic [3:0][31:0]   kw;
   logic [31:0]        rk0;
   logic               accept;

   sm4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // key whitening and first key schedule step
   always_comb begin
      kw[0] = key.key_high[63:32] ^ sm4_pkg::FK0;
      kw[1] = key.key_high[31:0]  ^ sm4_pkg::FK1;
      kw[2] = key.key_low[63:32]  ^ sm4_pkg::FK2;
      kw[3] = key.key_low[31:0]   ^ sm4_pkg::FK3;
      rk0   = kw[0] ^ sm4_pkg::sched_mix(kw[1] ^ kw[2] ^ kw[3] ^ sm4_pkg::ck_word(5'd0));
      setup_in.x  = {req_payload.plain_low[31:0], req_payload.plain_low[63:32],
                     req_payload.plain_high[31:0], req_payload.plain_high[63:32]};
      setup_in.k  = {rk0, kw[3], kw[2], kw[1]};
      setup_in.rk = rk0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_v_ff <= 1'b0;
      end else begin
         setup_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      setup_ff <= setup_in;
   end

   assign stage[0]   = setup_ff;
   assign stage_v[0] = setup_v_ff;

   for (genvar s = 1; s <= ROUNDS; s++) begin : g_round
      sm4_round #(
         .STAGE (s)
      ) u_round (
         .clock   (clock),
         .reset   (reset),
         .valid_i (stage_v[s-1]),
         .stage_i (stage[s-1]),
         .valid_o (stage_v[s]),
         .stage_o (stage[s])
      );
   end

   assign rsp_valid               = stage_v[ROUNDS];
   assign rsp_payload.cipher_high = {stage[ROUNDS].x[3], stage[ROUNDS].x[2]};
   assign rsp_payload.cipher_low  = {stage[ROUNDS].x[1], stage[ROUNDS].x[0]};

   a_enter: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_v[0])
      else $error("accepted item did not enter the setup stage");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, ROUNDS + 1))
      else $error("result without an item accepted at the pipeline latency");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !stage_v[0])
      else $error("setup stage valid without an accepted item");

endmodule
